// ===== src/ptd_pkg.sv =====
// ptd_pkg: shared types and codes of the periodic task dispatcher.
// Used by periodic_task_dispatcher_top; no dependencies of its own.

package ptd_pkg;

   // Default number of task entries
   localparam int MAX_TASKS_DEF = 16;

   // Widths of the fixed fields
   localparam int TIME_W   = 32;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 2;
   localparam int ID_W     = 4;

   // Request codes
   localparam logic [1:0] REQ_ADD   = 2'd0;
   localparam logic [1:0] REQ_TICK  = 2'd1;
   localparam logic [1:0] REQ_PAUSE = 2'd2;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FIRE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PAUSE = 2'd2;

   // Status codes
   localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_BADIDX = 2'd2;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FLUSH
   } state_type;

endpackage

// ===== src/ptd_ram.sv =====
// ptd_ram: generic simple dual-port RAM, one write and one registered read port.
// Stand-alone; no package needed.

module ptd_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read; data holds while the port is idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/periodic_task_dispatcher_top.sv =====
// Periodic task dispatcher: keeps a table of periodic tasks and reports which fire per tick.
// Depends on ptd_pkg and ptd_ram.
//
// Add and set-pause requests are taken once the result register is free and answer with a
// single transfer. A tick request walks the task table one entry per cycle, unless a stall
// holds the scan, through a single compare-and-add unit fed by the registered read port of
// the table RAM. The scan stalls while a fired result waits on a stalled result channel; a
// tick with no entry in use ends without a scan. One fired result is held back until the
// next one is found, so the final one can carry tlast. The block takes no request while a
// tick is being scanned.

module periodic_task_dispatcher_top #(
   parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] handler_present, [32:1] task_period, [64:33] tick_now,
   // [68:65] task_select, [69] pause_value, [71:70] zero
   input  logic [71:0] req_tdata,
   // [1:0] req_type
   input  logic [1:0]  req_tuser,
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [1:0] status, [5:2] task_id, [7:6] zero
   output logic [7:0]  rsp_tdata,
   // [1:0] result_kind
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   localparam int IW   = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CW   = $clog2(MAX_TASKS + 1);
   localparam int CMPW = (CW > ptd_pkg::ID_W) ? CW : ptd_pkg::ID_W;
   localparam int TW   = ptd_pkg::TIME_W;

   // Request fields
   logic                    req_handler;
   logic [TW-1:0]           req_period;
   logic [TW-1:0]           req_now;
   logic [ptd_pkg::ID_W-1:0] req_sel;
   logic                    req_pval;

   assign req_handler = req_tdata[0];
   assign req_period  = req_tdata[32:1];
   assign req_now     = req_tdata[64:33];
   assign req_sel     = req_tdata[68:65];
   assign req_pval    = req_tdata[69];

   // Control state
   ptd_pkg::state_type state_ff, state_in;
   logic [CW-1:0]        used_ff, used_in;
   logic [MAX_TASKS-1:0] pause_ff, pause_in;
   logic [CW-1:0]        rd_idx_ff, rd_idx_in;
   logic                 ev_valid_ff, ev_valid_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Payload state
   logic [TW-1:0]                  now_ff, now_in;
   logic [IW-1:0]                  ev_idx_ff, ev_idx_in;
   logic [IW-1:0]                  pend_idx_ff, pend_idx_in;
   logic [ptd_pkg::KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [ptd_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [ptd_pkg::ID_W-1:0]       rsp_id_ff, rsp_id_in;
   logic                           rsp_last_ff, rsp_last_in;

   // Table RAM: {period, due time} per entry
   logic            ram_wr_en;
   logic [IW-1:0]   ram_wr_addr;
   logic [2*TW-1:0] ram_wr_data;
   logic            ram_rd_en;
   logic [IW-1:0]   ram_rd_addr;
   logic [2*TW-1:0] ram_rd_data;

   ptd_ram #(
      .WIDTH(2 * TW),
      .DEPTH(MAX_TASKS)
   ) u_table (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // Shared compare-and-add unit on the entry under evaluation
   logic [TW-1:0] ev_period;
   logic [TW-1:0] ev_due;
   logic          ev_hit;
   logic [TW-1:0] ev_next_due;
   logic          ev_fire;

   assign ev_period   = ram_rd_data[2*TW-1:TW];
   assign ev_due      = ram_rd_data[TW-1:0];
   assign ev_hit      = now_ff > ev_due;
   assign ev_next_due = ev_period + now_ff;
   assign ev_fire     = ev_hit && !pause_ff[ev_idx_ff];

   logic                out_free;
   logic                stall;
   logic                issue;
   logic [CMPW-1:0]     sel_w;
   logic [CMPW-1:0]     used_w;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign sel_w    = CMPW'(req_sel);
   assign used_w   = CMPW'(used_ff);

   // Sequencer: next state, table access and result loading
   always_comb begin
      state_in      = state_ff;
      used_in       = used_ff;
      pause_in      = pause_ff;
      now_in        = now_ff;
      rd_idx_in     = rd_idx_ff;
      ev_valid_in   = ev_valid_ff;
      ev_idx_in     = ev_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = used_ff[IW-1:0];
      ram_wr_data   = {req_period, req_period};
      ram_rd_en     = 1'b0;
      ram_rd_addr   = rd_idx_ff[IW-1:0];
      req_tready    = 1'b0;
      stall         = 1'b0;
      issue         = 1'b0;

      unique case (state_ff)
         ptd_pkg::ST_IDLE: begin
            req_tready = out_free;
            if (req_tvalid && out_free) begin
               unique case (req_tuser)
                  ptd_pkg::REQ_ADD: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = ptd_pkg::KIND_ADD;
                     rsp_last_in  = 1'b1;
                     if (!req_handler || used_ff >= CW'(MAX_TASKS)) begin
                        rsp_status_in = ptd_pkg::STAT_FULL;
                        rsp_id_in     = '0;
                     end else begin
                        ram_wr_en                  = 1'b1;
                        pause_in[used_ff[IW-1:0]] = 1'b0;
                        rsp_status_in              = ptd_pkg::STAT_OK;
                        rsp_id_in                  = ptd_pkg::ID_W'(used_ff);
                        used_in                    = used_ff + 1'b1;
                     end
                  end
                  ptd_pkg::REQ_TICK: begin
                     now_in        = req_now;
                     rd_idx_in     = '0;
                     ev_valid_in   = 1'b0;
                     pend_valid_in = 1'b0;
                     if (used_ff != '0) begin
                        state_in = ptd_pkg::ST_SCAN;
                     end
                  end
                  ptd_pkg::REQ_PAUSE: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = ptd_pkg::KIND_PAUSE;
                     rsp_id_in    = req_sel;
                     rsp_last_in  = 1'b1;
                     if (sel_w >= used_w) begin
                        rsp_status_in = ptd_pkg::STAT_BADIDX;
                     end else begin
                        pause_in[sel_w[IW-1:0]] = req_pval;
                        rsp_status_in           = ptd_pkg::STAT_OK;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ptd_pkg::ST_SCAN: begin
            // hold everything while a fired result cannot leave
            stall = ev_valid_ff && ev_fire && pend_valid_ff && !out_free;
            if (ev_valid_ff && !stall) begin
               if (ev_hit) begin
                  ram_wr_en   = 1'b1;
                  ram_wr_addr = ev_idx_ff;
                  ram_wr_data = {ev_period, ev_next_due};
               end
               if (ev_fire) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_kind_in   = ptd_pkg::KIND_FIRE;
                     rsp_status_in = ptd_pkg::STAT_OK;
                     rsp_id_in     = ptd_pkg::ID_W'(pend_idx_ff);
                     rsp_last_in   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = ev_idx_ff;
               end
            end
            // advance the read pointer
            issue = !stall && (rd_idx_ff < used_ff);
            if (issue) begin
               ram_rd_en   = 1'b1;
               ev_valid_in = 1'b1;
               ev_idx_in   = rd_idx_ff[IW-1:0];
               rd_idx_in   = rd_idx_ff + 1'b1;
            end else if (!stall) begin
               ev_valid_in = 1'b0;
               state_in    = ptd_pkg::ST_FLUSH;
            end
         end

         ptd_pkg::ST_FLUSH: begin
            // release the held result with the last flag
            if (!pend_valid_ff) begin
               state_in = ptd_pkg::ST_IDLE;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = ptd_pkg::KIND_FIRE;
               rsp_status_in = ptd_pkg::STAT_OK;
               rsp_id_in     = ptd_pkg::ID_W'(pend_idx_ff);
               rsp_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ptd_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ptd_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ptd_pkg::ST_IDLE;
         used_ff       <= '0;
         pause_ff      <= '0;
         rd_idx_ff     <= '0;
         ev_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         pause_ff      <= pause_in;
         rd_idx_ff     <= rd_idx_in;
         ev_valid_ff   <= ev_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      ev_idx_ff     <= ev_idx_in;
      pend_idx_ff   <= pend_idx_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_id_ff, rsp_status_ff};
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Checks on the sequencer
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= CW'(MAX_TASKS))
      else $error("entry count beyond table size");

   a_read_in_use: assert property (@(posedge clock) disable iff (reset)
      ram_rd_en |-> (rd_idx_ff < used_ff))
      else $error("table read beyond entries in use");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (CW'(ram_wr_addr) <= used_ff))
      else $error("table write beyond appended entry");

   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ptd_pkg::ST_IDLE) |-> (!pend_valid_ff && !ev_valid_ff))
      else $error("scan left a result or entry behind");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      stall |=> (ev_valid_ff && $stable(ev_idx_ff) && pend_valid_ff))
      else $error("evaluated entry lost during stall");

endmodule
